// ===== rtl/gncd_pkg.sv =====
package gncd_pkg;

  // item kinds on the input stream
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // register indexes on the configuration port
  localparam logic [1:0] REG_GRID_FULL  = 2'd0;
  localparam logic [1:0] REG_GRID_WIDTH = 2'd1;
  localparam logic [1:0] REG_GRID_SCALE = 2'd2;
  localparam logic [1:0] REG_CELL_SIZE  = 2'd3;

  localparam int ADDR_W  = 4;
  localparam int PDATA_W = 32;

  localparam int KIND_W  = 2;
  localparam int CELL_W  = 6;
  localparam int COORD_W = 21;
  localparam int WIDTH_W = 6;
  localparam int SCALE_W = 20;
  localparam int SIZE_W  = 17;
  localparam int ENTRY_W = 2 * CELL_W;

  localparam int IN_DATA_W  = 56;
  localparam int DIST_W     = 22;
  localparam int OUT_DATA_W = 24;

  // cell mapping: positive offset point times scale, cell index in bits 32 and up
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = COORD_W + SCALE_W;
  localparam int RAW_W  = PROD_W - 32;

  // distance datapath widths (Q17 differences, Q16 result)
  localparam int MUL_W = CELL_W + 1 + SIZE_W;
  localparam int AX_W  = 26;
  localparam int UX_W  = AX_W - 1;
  localparam int SQ_W  = 2 * UX_W;
  localparam int D_W   = SQ_W + 1 - 18;
  localparam int GD_W  = 2 * CELL_W + 1;

  localparam int DIST_LAT     = 4;
  localparam int DRAIN_CYCLES = DIST_LAT + 1;
  localparam int DRAIN_W      = $clog2(DRAIN_CYCLES + 1);

  typedef struct packed {
    logic               full;
    logic [WIDTH_W-1:0] width;
    logic [SCALE_W-1:0] scale;
    logic [SIZE_W-1:0]  cell_size;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    logic [GD_W-1:0] gd;
    logic [D_W-1:0]  d;
  } dist_res_t;

endpackage

// ===== rtl/grid_nearest_centre_distance.sv =====
// channel  dir  handshake         payload
// s_*      in   s_tvalid/tready   tdata: cell_col, cell_row, point_x, point_y; tuser: kind
// m_*      out  m_tvalid/tready   tdata: distance_sq; tuser: list_empty
// apb      in   psel/penable      registers grid_full, grid_width, grid_scale, cell_size
//
// clear and append items only update the centre list; nothing comes out for them
// a query passes map, issue, drain and done states; full mode issues the point's own cell,
// partial mode the stored list: the scan reads one stored centre per cycle from the read port
// rst is synchronous; it empties the centre list, the store itself is not cleared
// a finished result waits in the output register; the next item is taken meanwhile,
// but a query cannot finish while the previous result is still waiting
module grid_nearest_centre_distance #(
  parameter int MAX_CENTRES  = 4096,
  parameter int COORD_SPAN   = 4,
  parameter int LOWEST_COORD = -2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // cell_col[5:0], cell_row[11:6], point_x[32:12], point_y[53:33], zero pad
  input  logic [gncd_pkg::IN_DATA_W-1:0]   s_tdata,
  // kind[1:0]
  input  logic [gncd_pkg::KIND_W-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // distance_sq[21:0], zero pad
  output logic [gncd_pkg::OUT_DATA_W-1:0]  m_tdata,
  // list_empty[0]
  output logic                             m_tuser,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gncd_pkg::ADDR_W-1:0]      paddr,
  input  logic [gncd_pkg::PDATA_W-1:0]     pwdata,
  output logic [gncd_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);
  import gncd_pkg::*;

  localparam int AW = (MAX_CENTRES > 1) ? $clog2(MAX_CENTRES) : 1;
  localparam int CW = $clog2(MAX_CENTRES + 1);
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_CENTRES);
  localparam logic [D_W-1:0] SAT = D_W'((1 + 2 * COORD_SPAN * COORD_SPAN) * 65536 - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAP   = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  cfg_t       cfg;
  dist_res_t  res;

  logic [2:0]  state, state_next;
  logic        accept;
  logic [KIND_W-1:0] in_kind;
  logic [CELL_W-1:0] in_col, in_row;

  logic signed [COORD_W-1:0] px, py;
  logic [CELL_W-1:0]         gx, gy;

  logic [ENTRY_W-1:0] store [MAX_CENTRES];
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_valid;
  logic               rd_en;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [DRAIN_W-1:0] drain;

  logic            have;
  logic [GD_W-1:0] best_gd;
  logic [D_W-1:0]  best_d;
  logic [D_W-1:0]  final_d;
  logic            out_load;

  logic              feed_valid;
  logic [CELL_W-1:0] feed_cx, feed_cy;

  assign in_kind = s_tuser;
  assign in_col  = s_tdata[CELL_W-1:0];
  assign in_row  = s_tdata[2*CELL_W-1:CELL_W];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  gncd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gncd_cell #(
    .LOWEST_COORD (LOWEST_COORD)
  ) u_cell (
    .clk (clk),
    .px  (px),
    .py  (py),
    .cfg (cfg),
    .gx  (gx),
    .gy  (gy)
  );

  // full mode feeds the point's own cell once, partial mode the stored cells
  assign feed_valid = cfg.full ? (state == ST_ISSUE) : rd_valid;
  assign feed_cx    = cfg.full ? gx : rd_data[CELL_W-1:0];
  assign feed_cy    = cfg.full ? gy : rd_data[ENTRY_W-1:CELL_W];

  gncd_dist #(
    .LOWEST_COORD (LOWEST_COORD)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (feed_valid),
    .px        (px),
    .py        (py),
    .cx        (feed_cx),
    .cy        (feed_cy),
    .gx        (gx),
    .gy        (gy),
    .cell_size (cfg.cell_size),
    .res       (res)
  );

  assign rd_en = (state == ST_ISSUE) && !cfg.full && (idx < count);

  always_ff @(posedge clk) begin
    if (accept && (in_kind == KIND_APPEND) && (count < MAX_COUNT))
      store[count[AW-1:0]] <= {in_row, in_col};
    if (rd_en)
      rd_data <= store[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept && (in_kind == KIND_QUERY)) begin
      px <= $signed(s_tdata[2*CELL_W+COORD_W-1:2*CELL_W]);
      py <= $signed(s_tdata[2*CELL_W+2*COORD_W-1:2*CELL_W+COORD_W]);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && (in_kind == KIND_QUERY)) state_next = ST_MAP;
      ST_MAP:   state_next = ST_ISSUE;
      ST_ISSUE: if (cfg.full || (idx >= count)) state_next = ST_DRAIN;
      ST_DRAIN: if (drain == DRAIN_W'(DRAIN_CYCLES - 1)) state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign final_d  = (have && (best_d < SAT)) ? best_d : SAT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      idx      <= '0;
      drain    <= '0;
      rd_valid <= 1'b0;
      have     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_en;

      if (accept && (in_kind == KIND_CLEAR))
        count <= '0;
      else if (accept && (in_kind == KIND_APPEND) && (count < MAX_COUNT))
        count <= count + CW'(1);

      if (state == ST_MAP)
        idx <= '0;
      else if (rd_en)
        idx <= idx + CW'(1);

      if (state == ST_DRAIN)
        drain <= drain + DRAIN_W'(1);
      else
        drain <= '0;

      // keep the least grid distance, and among equal ones the least distance
      if (state == ST_MAP)
        have <= 1'b0;
      else if (res.valid)
        have <= 1'b1;

      if (out_load)
        m_tvalid <= 1'b1;
      else if (m_tready)
        m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && (!have || (res.gd < best_gd) ||
                      ((res.gd == best_gd) && (res.d < best_d)))) begin
      best_gd <= res.gd;
      best_d  <= res.d;
    end
    if (out_load) begin
      m_tdata <= OUT_DATA_W'(final_d[DIST_W-1:0]);
      m_tuser <= !have && !cfg.full;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_COUNT)
    else $error("centre count above capacity");

  a_read_in_list: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> ($past(idx) < count))
    else $error("store read beyond the stored list");

  a_list_stable_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE || state == ST_DRAIN) |=> $stable(count))
    else $error("centre list changed during a scan");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside the finishing state");

  a_no_feed_late: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (!feed_valid && !rd_valid))
    else $error("distance work still issued when the query finishes");

endmodule

// ===== rtl/gncd_regs.sv =====
module gncd_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gncd_pkg::ADDR_W-1:0]   paddr,
  input  logic [gncd_pkg::PDATA_W-1:0]  pwdata,
  output logic [gncd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output gncd_pkg::cfg_t                cfg
);
  import gncd_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full      <= 1'b1;
      cfg.width     <= WIDTH_W'(4);
      cfg.scale     <= SCALE_W'(65536);
      cfg.cell_size <= SIZE_W'(65536);
    end else if (wr_en) begin
      case (reg_idx)
        REG_GRID_FULL:  cfg.full      <= pwdata[0];
        REG_GRID_WIDTH: cfg.width     <= pwdata[WIDTH_W-1:0];
        REG_GRID_SCALE: cfg.scale     <= pwdata[SCALE_W-1:0];
        REG_CELL_SIZE:  cfg.cell_size <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRID_FULL:  prdata = PDATA_W'(cfg.full);
      REG_GRID_WIDTH: prdata = PDATA_W'(cfg.width);
      REG_GRID_SCALE: prdata = PDATA_W'(cfg.scale);
      REG_CELL_SIZE:  prdata = PDATA_W'(cfg.cell_size);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/gncd_cell.sv =====
module gncd_cell #(
  parameter int LOWEST_COORD = -2
) (
  input  logic                                clk,
  input  logic signed [gncd_pkg::COORD_W-1:0] px,
  input  logic signed [gncd_pkg::COORD_W-1:0] py,
  input  gncd_pkg::cfg_t                      cfg,
  output logic [gncd_pkg::CELL_W-1:0]         gx,
  output logic [gncd_pkg::CELL_W-1:0]         gy
);
  import gncd_pkg::*;

  localparam logic signed [DIFF_W-1:0] OFFSET = DIFF_W'(-LOWEST_COORD * 65536);

  logic signed [COORD_W-1:0] p [2];
  logic signed [DIFF_W-1:0]  diff [2];
  logic [PROD_W-1:0]         prod [2];
  logic [RAW_W-1:0]          raw [2];
  logic                      pos [2];
  logic [CELL_W-1:0]         g [2];
  logic [CELL_W-1:0]         gmax;

  assign p[0] = px;
  assign p[1] = py;
  assign gmax = (cfg.width == '0) ? '0 : CELL_W'(cfg.width - WIDTH_W'(1));

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      diff[a] = DIFF_W'(p[a]) + OFFSET;
      prod[a] = PROD_W'(diff[a][COORD_W-1:0]) * PROD_W'(cfg.scale);
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      raw[a] <= prod[a][PROD_W-1:32];
      pos[a] <= !diff[a][DIFF_W-1] && (diff[a] != '0);
    end
  end

  // points at or below the low edge land in cell 0, beyond the top clamp
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (!pos[a])
        g[a] = '0;
      else if (raw[a] > RAW_W'(gmax))
        g[a] = gmax;
      else
        g[a] = raw[a][CELL_W-1:0];
    end
  end

  assign gx = g[0];
  assign gy = g[1];

endmodule

// ===== rtl/gncd_dist.sv =====
module gncd_dist #(
  parameter int LOWEST_COORD = -2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic signed [gncd_pkg::COORD_W-1:0] px,
  input  logic signed [gncd_pkg::COORD_W-1:0] py,
  input  logic [gncd_pkg::CELL_W-1:0]         cx,
  input  logic [gncd_pkg::CELL_W-1:0]         cy,
  input  logic [gncd_pkg::CELL_W-1:0]         gx,
  input  logic [gncd_pkg::CELL_W-1:0]         gy,
  input  logic [gncd_pkg::SIZE_W-1:0]         cell_size,
  output gncd_pkg::dist_res_t                 res
);
  import gncd_pkg::*;

  localparam logic signed [AX_W-1:0] BASE = AX_W'(LOWEST_COORD * 131072);

  logic signed [COORD_W-1:0] p [2];
  logic [CELL_W-1:0]         c [2];
  logic [CELL_W-1:0]         g [2];
  logic signed [CELL_W:0]    e [2];
  logic [CELL_W-1:0]         ae [2];
  logic [2*CELL_W-1:0]       esq [2];
  logic signed [AX_W-1:0]    ax [2];
  logic signed [AX_W-1:0]    dx [2];
  logic [UX_W-1:0]           ux [2];

  logic [MUL_W-1:0] m1 [2];
  logic [UX_W-1:0]  u2 [2];
  logic [SQ_W-1:0]  s3 [2];
  logic [GD_W-1:0]  gd1, gd2, gd3;
  logic             v1, v2, v3;

  assign p[0] = px;
  assign p[1] = py;
  assign c[0] = cx;
  assign c[1] = cy;
  assign g[0] = gx;
  assign g[1] = gy;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      e[a]   = $signed({1'b0, c[a]}) - $signed({1'b0, g[a]});
      ae[a]  = e[a][CELL_W] ? CELL_W'(-e[a]) : e[a][CELL_W-1:0];
      esq[a] = (2*CELL_W)'(ae[a]) * (2*CELL_W)'(ae[a]);
      // centre on this axis in Q17: base plus (2c+1) cell sizes
      ax[a]  = BASE + $signed(AX_W'(m1[a]));
      dx[a]  = $signed({{(AX_W-COORD_W-1){p[a][COORD_W-1]}}, p[a], 1'b0}) - ax[a];
      ux[a]  = dx[a][AX_W-1] ? UX_W'(-dx[a]) : dx[a][UX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      m1[a] <= MUL_W'({c[a], 1'b1}) * MUL_W'(cell_size);
      u2[a] <= ux[a];
      s3[a] <= SQ_W'(u2[a]) * SQ_W'(u2[a]);
    end
    gd1    <= GD_W'(esq[0]) + GD_W'(esq[1]);
    gd2    <= gd1;
    gd3    <= gd2;
    res.gd <= gd3;
    res.d  <= D_W'(((SQ_W+1)'(s3[0]) + (SQ_W+1)'(s3[1])) >> 18);
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      res.valid <= v3;
    end
  end

endmodule
